// ----- rtl/core/dither_fill_byte_packer_top_defines.svh -----
// ----------------------------------------------------------------------------
// dither_fill_byte_packer_top_defines.svh
// Assertion macros for the dither fill byte packer. Synthesis builds define
// SYNTH, which turns every check into nothing.
// ----------------------------------------------------------------------------
`ifndef DITHER_FILL_BYTE_PACKER_TOP_DEFINES_SVH
`define DITHER_FILL_BYTE_PACKER_TOP_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication
`define DFBP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("dfbp check failed");
// next-cycle implication
`define DFBP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("dfbp check failed");
`else
`define DFBP_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define DFBP_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ----- rtl/core/dfbp_pkg.sv -----
// ----------------------------------------------------------------------------
// dfbp_pkg
// Shared types, constants and the dither rule of the byte packer.
// ----------------------------------------------------------------------------
package dfbp_pkg;

	// framebuffer geometry
	localparam int MAX_ROW_PIXELS = 1024;
	localparam int PATTERN_PERIOD = 8;
	localparam int PIX_PER_BYTE   = 4;
	localparam int PIX_W          = 2;
	localparam int PER_W          = $clog2(PATTERN_PERIOD);
	localparam int SUB_W          = $clog2(PIX_PER_BYTE);

	// field widths
	localparam int BIDX_W  = 8;
	localparam int ROW_W   = 10;
	localparam int COL_W   = 11;
	localparam int BYTE_W  = 8;
	localparam int ADDR_W  = 18;
	localparam int PAT_W   = 3;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 11;
	localparam int PXCOL_W = BIDX_W + SUB_W;

	// noise rule constants
	localparam int NOISE_MUL_X  = 17;
	localparam int NOISE_MUL_Y  = 31;
	localparam int NOISE_THRESH = 3;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MONO        = 3'd0,
		REG_ROW_PIXELS  = 3'd1,
		REG_CODE_BLACK  = 3'd2,
		REG_CODE_WHITE  = 3'd3,
		REG_CODE_YELLOW = 3'd4,
		REG_CODE_RED    = 3'd5
	} cfg_reg_t;

	typedef enum logic [PAT_W-1:0] {
		PAT_NONE       = 3'd0,
		PAT_GRAY       = 3'd1,
		PAT_LIGHT_GRAY = 3'd2,
		PAT_ORANGE     = 3'd3,
		PAT_GOLD       = 3'd4,
		PAT_PEACH      = 3'd5,
		PAT_NOISE      = 3'd6,
		PAT_SOFT       = 3'd7
	} pattern_t;

	// panel colour setup
	typedef struct packed {
		logic             mono;
		logic [PIX_W-1:0] black;
		logic [PIX_W-1:0] white;
		logic [PIX_W-1:0] yellow;
		logic [PIX_W-1:0] red;
	} color_cfg_t;

	// normalized style of one item
	typedef struct packed {
		pattern_t         pat;
		logic [PIX_W-1:0] on_c;
		logic [PIX_W-1:0] off_c;
	} style_t;

	// what one pixel lane found
	typedef struct packed {
		logic [PIX_W-1:0] color;
		logic             hit;
	} lane_out_t;

	// dither rule on the low column and row bits
	function automatic logic pattern_on(pattern_t pat, logic [PER_W-1:0] x,
			logic [PER_W-1:0] y);
		logic [7:0] nx;
		logic [7:0] ny;
		logic [PER_W-1:0] nv;
		logic on;
		nx = 8'(x) * 8'(NOISE_MUL_X);
		ny = 8'(y) * 8'(NOISE_MUL_Y);
		nv = nx[PER_W-1:0] ^ ny[PER_W-1:0];
		case (pat) inside
			PAT_GRAY:            on = (x[0] == 1'b0) && (y[0] == 1'b0);
			PAT_LIGHT_GRAY:      on = (x[1:0] == 2'd0) && (y[1:0] == 2'd0);
			PAT_ORANGE, PAT_GOLD: on = (x[1:0] != 2'd0) || (y[1:0] != 2'd0);
			PAT_PEACH:           on = (x[1:0] == 2'd0) && (y[0] == 1'b0);
			PAT_NOISE:           on = nv < PER_W'(NOISE_THRESH);
			PAT_SOFT:            on = (x == '0) && (y[1:0] == 2'd0);
			default:             on = 1'b0;
		endcase
		return on;
	endfunction

endpackage

// ----- rtl/core/dfbp_norm.sv -----
// ----------------------------------------------------------------------------
// dfbp_norm
// Mono-panel colour and pattern cleanup, then on/off colour choice.
// ----------------------------------------------------------------------------
module dfbp_norm (
	input  dfbp_pkg::color_cfg_t          cfg,
	input  logic [dfbp_pkg::PAT_W-1:0]    pattern,
	input  logic [dfbp_pkg::PIX_W-1:0]    fg_color,
	input  logic [dfbp_pkg::PIX_W-1:0]    bg_color,
	output dfbp_pkg::style_t              style
);
	import dfbp_pkg::*;

	pattern_t         pat_v;
	logic [PIX_W-1:0] fg_v;
	logic [PIX_W-1:0] bg_v;

	// rules run in fixed order; coinciding codes take the first match
	always_comb begin
		pat_v = pattern_t'(pattern);
		fg_v  = fg_color;
		bg_v  = bg_color;
		if (cfg.mono) begin
			if (bg_v == cfg.red || bg_v == cfg.yellow) begin
				bg_v = cfg.white;
				if (pat_v == PAT_NONE) begin
					pat_v = PAT_LIGHT_GRAY;
				end
			end
			if (fg_v == cfg.red || fg_v == cfg.yellow) begin
				fg_v = cfg.black;
			end
			if (bg_v == cfg.black && fg_v == cfg.black) begin
				fg_v = cfg.white;
			end else if (bg_v == cfg.white && fg_v == cfg.white) begin
				fg_v = cfg.black;
			end
			// colour dithers degrade to light gray
			if (pat_v inside {PAT_ORANGE, PAT_PEACH, PAT_GOLD}) begin
				pat_v = PAT_LIGHT_GRAY;
			end
		end
	end

	// fixed colours for the colour dithers, style colours otherwise
	always_comb begin
		style.pat = pat_v;
		case (pat_v)
			PAT_ORANGE: begin
				style.on_c  = cfg.yellow;
				style.off_c = cfg.red;
			end
			PAT_PEACH: begin
				style.on_c  = cfg.red;
				style.off_c = cfg.white;
			end
			PAT_GOLD: begin
				style.on_c  = cfg.yellow;
				style.off_c = cfg.white;
			end
			default: begin
				style.on_c  = fg_v;
				style.off_c = bg_v;
			end
		endcase
	end

endmodule

// ----- rtl/core/dfbp_lane.sv -----
// ----------------------------------------------------------------------------
// dfbp_lane
// One pixel of the byte: dither colour and run membership.
// ----------------------------------------------------------------------------
module dfbp_lane (
	input  dfbp_pkg::style_t               style,
	input  logic [dfbp_pkg::PXCOL_W-1:0]   col,
	input  logic [dfbp_pkg::PER_W-1:0]     row_lo,
	input  logic [dfbp_pkg::COL_W-1:0]     run_start,
	input  logic [dfbp_pkg::COL_W-1:0]     run_end,
	output dfbp_pkg::lane_out_t            result
);
	import dfbp_pkg::*;

	logic [COL_W-1:0] col_x;

	assign col_x = COL_W'(col);

	// pixel colour from the pattern, hit when inside [start, end)
	always_comb begin
		result.color = pattern_on(style.pat, col[PER_W-1:0], row_lo) ?
			style.on_c : style.off_c;
		result.hit   = (col_x >= run_start) && (col_x < run_end);
	end

endmodule

// ----- rtl/core/dfbp_merge.sv -----
// ----------------------------------------------------------------------------
// dfbp_merge
// Packs the lane colours and merges pixels in the run into the old byte.
// ----------------------------------------------------------------------------
module dfbp_merge (
	input  dfbp_pkg::lane_out_t [dfbp_pkg::PIX_PER_BYTE-1:0] lanes,
	input  logic [dfbp_pkg::BYTE_W-1:0]                     old_byte,
	output logic [dfbp_pkg::BYTE_W-1:0]                     new_byte,
	output logic                                            write_flag
);
	import dfbp_pkg::*;

	logic [BYTE_W-1:0] packed_px;
	logic [BYTE_W-1:0] mask;

	// lane 0 is the leftmost pixel, in the top bits
	always_comb begin
		packed_px  = '0;
		mask       = '0;
		write_flag = 1'b0;
		for (int i = 0; i < PIX_PER_BYTE; i++) begin
			packed_px[(PIX_PER_BYTE-1-i)*PIX_W +: PIX_W] = lanes[i].color;
			mask[(PIX_PER_BYTE-1-i)*PIX_W +: PIX_W]      = {PIX_W{lanes[i].hit}};
			write_flag = write_flag | lanes[i].hit;
		end
		new_byte = (old_byte & ~mask) | (packed_px & mask);
	end

endmodule

// ----- rtl/core/dither_fill_byte_packer_top.sv -----
// ----------------------------------------------------------------------------
// dither_fill_byte_packer_top
// Dithered fill of one 2-bit-per-pixel framebuffer byte with its address.
// ----------------------------------------------------------------------------
// Takes one item per clock and never stalls: busy stays low. Each item passes
// the stage 1 and stage 2 registers and comes out on the cycle done is high;
// the receiver must take it then. Stage 1 normalizes the style and forms row
// times bytes per row in one multiplier; stage 2 runs four pixel lanes side by
// side, merges them into the old byte and adds the byte index. Configuration
// writes land at once and should be made with no item in flight.
`include "dither_fill_byte_packer_top_defines.svh"

module dither_fill_byte_packer_top (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration
	input  logic                                cfg_we,
	input  logic [dfbp_pkg::CFG_IDX_W-1:0]      cfg_idx,
	input  logic [dfbp_pkg::CFG_DATA_W-1:0]     cfg_wdata,
	// command
	input  logic                                start,
	output logic                                busy,
	input  logic [dfbp_pkg::BIDX_W-1:0]         byte_index,
	input  logic [dfbp_pkg::ROW_W-1:0]          row,
	input  logic [dfbp_pkg::COL_W-1:0]          run_start,
	input  logic [dfbp_pkg::COL_W-1:0]          run_end,
	input  logic [dfbp_pkg::PAT_W-1:0]          pattern,
	input  logic [dfbp_pkg::PIX_W-1:0]          fg_color,
	input  logic [dfbp_pkg::PIX_W-1:0]          bg_color,
	input  logic [dfbp_pkg::BYTE_W-1:0]         old_byte,
	// result
	output logic                                done,
	output logic [dfbp_pkg::BYTE_W-1:0]         new_byte,
	output logic [dfbp_pkg::ADDR_W-1:0]         byte_address,
	output logic                                write_flag
);
	import dfbp_pkg::*;

	localparam int WP2_W = COL_W + 1;
	localparam int BPR_W = $clog2(MAX_ROW_PIXELS * PIX_W / BYTE_W + 1);
	localparam int PROD_W = ROW_W + BPR_W;

	// configuration registers
	logic             mono_q;
	logic [COL_W-1:0] row_pixels_q;
	logic [PIX_W-1:0] code_black_q;
	logic [PIX_W-1:0] code_white_q;
	logic [PIX_W-1:0] code_yellow_q;
	logic [PIX_W-1:0] code_red_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mono_q        <= 1'b0;
			row_pixels_q  <= COL_W'(MAX_ROW_PIXELS);
			code_black_q  <= 2'd0;
			code_white_q  <= 2'd1;
			code_yellow_q <= 2'd2;
			code_red_q    <= 2'd3;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_idx))
				REG_MONO:        mono_q        <= cfg_wdata[0];
				REG_ROW_PIXELS:  row_pixels_q  <= cfg_wdata[COL_W-1:0];
				REG_CODE_BLACK:  code_black_q  <= cfg_wdata[PIX_W-1:0];
				REG_CODE_WHITE:  code_white_q  <= cfg_wdata[PIX_W-1:0];
				REG_CODE_YELLOW: code_yellow_q <= cfg_wdata[PIX_W-1:0];
				REG_CODE_RED:    code_red_q    <= cfg_wdata[PIX_W-1:0];
				default: ;
			endcase
		end
	end

	color_cfg_t cfg;
	assign cfg = '{mono: mono_q, black: code_black_q, white: code_white_q,
		yellow: code_yellow_q, red: code_red_q};

	// bytes per row from the saturated row width
	logic [COL_W-1:0] wp;
	logic [WP2_W-1:0] wp2;
	logic [BPR_W-1:0] bpr;

	always_comb begin
		wp  = (row_pixels_q > COL_W'(MAX_ROW_PIXELS)) ? COL_W'(MAX_ROW_PIXELS)
			: row_pixels_q;
		wp2 = {wp, 1'b0} + WP2_W'(BYTE_W - 1);
		bpr = BPR_W'(wp2 >> $clog2(BYTE_W));
	end

	assign busy = 1'b0;

	// stage 1: style cleanup and row offset product
	style_t            style;
	logic              accept;
	logic [PROD_W-1:0] prod;

	assign accept = start && !busy;
	assign prod   = PROD_W'(row) * PROD_W'(bpr);

	dfbp_norm u_norm (
		.cfg      (cfg),
		.pattern  (pattern),
		.fg_color (fg_color),
		.bg_color (bg_color),
		.style    (style)
	);

	logic              valid_s1;
	style_t            style_s1;
	logic [BIDX_W-1:0] bidx_s1;
	logic [PER_W-1:0]  row_lo_s1;
	logic [COL_W-1:0]  rs_s1;
	logic [COL_W-1:0]  re_s1;
	logic [BYTE_W-1:0] old_s1;
	logic [ADDR_W-1:0] prod_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			style_s1  <= style;
			bidx_s1   <= byte_index;
			row_lo_s1 <= row[PER_W-1:0];
			rs_s1     <= run_start;
			re_s1     <= run_end;
			old_s1    <= old_byte;
			prod_s1   <= prod[ADDR_W-1:0];
		end
	end

	// stage 2: pixel lanes, merge and address add
	lane_out_t [PIX_PER_BYTE-1:0] lanes;
	logic [BYTE_W-1:0]            merged;
	logic                         any_hit;

	for (genvar i = 0; i < PIX_PER_BYTE; i++) begin : g_lane
		dfbp_lane u_lane (
			.style     (style_s1),
			.col       ({bidx_s1, SUB_W'(i)}),
			.row_lo    (row_lo_s1),
			.run_start (rs_s1),
			.run_end   (re_s1),
			.result    (lanes[i])
		);
	end

	dfbp_merge u_merge (
		.lanes      (lanes),
		.old_byte   (old_s1),
		.new_byte   (merged),
		.write_flag (any_hit)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			new_byte     <= merged;
			byte_address <= prod_s1 + ADDR_W'(bidx_s1);
			write_flag   <= any_hit;
		end
	end

	// checks
	`DFBP_ASSERT_NEXT(a_s1_to_done, clk, arst_n, valid_s1, done)
	`DFBP_ASSERT_NOW(a_nowrite_keeps_old, clk, arst_n, done && !write_flag, new_byte == $past(old_s1))
	`DFBP_ASSERT_NOW(a_write_needs_run, clk, arst_n, done && write_flag, $past(rs_s1 < re_s1))

endmodule
